FILE: hdl/lfu_pkg.sv
// shared constants, types and cell commands for the lfu cache table
package lfu_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int KEY_W = 16;
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TOUCH,
    CELL_UPDATE,
    CELL_EVICT,
    CELL_FILL
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EVICT,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef struct packed {
    cell_op_t          op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  ref_rank;
    logic [OCC_W-1:0]  occ;
  } cmd_t;

  // running victim candidate handed down the row
  typedef struct packed {
    logic                   valid;
    logic [COUNT_WIDTH-1:0] count;
    logic [IDX_W-1:0]       rank;
    logic [IDX_W-1:0]       idx;
  } cand_t;

endpackage

FILE: hdl/lfu_cell.sv
// one cache entry: key, value, use count, recency rank and a victim search stage
module lfu_cell
  import lfu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             sel,
  input  logic [IDX_W-1:0] own_idx,
  input  cand_t            cand_in,
  output cand_t            cand_out,
  output logic             match,
  output logic             valid,
  output logic [VAL_W-1:0] value,
  output logic [IDX_W-1:0] rank
);

  logic [KEY_W-1:0]       key;
  logic [COUNT_WIDTH-1:0] count;
  logic                   own_better;

  assign match = valid && (key == cmd.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
      rank  <= '0;
    end else begin
      case (cmd.op)
        CELL_TOUCH, CELL_UPDATE: begin
          if (sel) begin
            rank <= IDX_W'(cmd.occ - 1'b1);
            if (count != '1) count <= count + 1'b1;
          end else if (valid && rank > cmd.ref_rank) begin
            rank <= rank - 1'b1;
          end
        end
        CELL_EVICT: begin
          if (sel) begin
            valid <= 1'b0;
            count <= '0;
            rank  <= '0;
          end else if (valid && rank > cmd.ref_rank) begin
            rank <= rank - 1'b1;
          end
        end
        CELL_FILL: begin
          if (sel) begin
            valid <= 1'b1;
            count <= COUNT_WIDTH'(1);
            rank  <= IDX_W'(cmd.occ);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && (cmd.op == CELL_UPDATE || cmd.op == CELL_FILL)) value <= cmd.value;
    if (sel && cmd.op == CELL_FILL) key <= cmd.key;
  end

  // lower count wins, equal counts go to the older access
  assign own_better = valid && (!cand_in.valid || count < cand_in.count ||
                      (count == cand_in.count && rank < cand_in.rank));

  always_ff @(posedge clk) begin
    if (own_better) begin
      cand_out.valid <= 1'b1;
      cand_out.count <= count;
      cand_out.rank  <= rank;
      cand_out.idx   <= own_idx;
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

FILE: hdl/lfu_cache_table.sv
// lfu cache table top level: request control, row of entry cells, result register
// Usage:
//   Requests come in on in_valid/in_stall with req_type (0 get, 1 put),
//   lookup_key and store_value. A get makes one result on out_valid/out_stall
//   (hit, read_value = -1 on miss); a put makes none. The user must write
//   capacity_in_use via cfg_write/cfg_data only while idle; it is not enforced.
// Timing:
//   A get or a put of a present key is done in ST_EXEC, where a get's result
//   is loaded into the result register. A put of a new key adds ST_FILL, and
//   ST_SCAN and ST_EVICT before it when an entry must be evicted: the victim
//   is found by a running minimum passed one cell per cycle down the row.
//   One request is in the table at a time since the next depends on it.
// Reset:
//   all entries empty, occupancy zero, capacity MAX_ENTRIES.
// Stalls:
//   the result register holds while out_stall is high; a new request is
//   still accepted, and a get finishing behind a stalled result waits.
module lfu_cache_table
  import lfu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CAP_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    req_type,
  input  logic [KEY_W-1:0]        lookup_key,
  input  logic signed [VAL_W-1:0] store_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value
);

  state_t            state, state_next;
  logic [CAP_W-1:0]  capacity_in_use;
  logic [OCC_W-1:0]  occupancy, occupancy_next;
  logic [OCC_W-1:0]  scan_cnt;
  logic              req_put;
  logic [KEY_W-1:0]  req_key;
  logic [VAL_W-1:0]  req_value;
  logic              pend_hit;
  logic [VAL_W-1:0]  pend_value;

  cmd_t              cmd;
  logic [MAX_ENTRIES-1:0] sel, hit_vec, valid_vec;
  logic [VAL_W-1:0]  cell_value [MAX_ENTRIES];
  logic [IDX_W-1:0]  cell_rank [MAX_ENTRIES];
  cand_t             cand [MAX_ENTRIES];

  logic              any_hit;
  logic [VAL_W-1:0]  hit_value;
  logic [IDX_W-1:0]  hit_rank;
  logic [IDX_W-1:0]  free_idx;
  logic              out_free;
  logic              load_out, load_pend;
  logic              new_hit;
  logic [VAL_W-1:0]  new_value;
  logic              need_evict;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cand_t left;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = cand[i-1];
    end
    lfu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (sel[i]),
      .own_idx  (IDX_W'(i)),
      .cand_in  (left),
      .cand_out (cand[i]),
      .match    (hit_vec[i]),
      .valid    (valid_vec[i]),
      .value    (cell_value[i]),
      .rank     (cell_rank[i])
    );
  end

  // keys are unique, so at most one cell matches
  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    free_idx  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_value = hit_value | cell_value[i];
        hit_rank  = hit_rank | cell_rank[i];
      end
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_vec[i]) free_idx = IDX_W'(i);
    end
  end

  assign any_hit    = |hit_vec;
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE);
  assign need_evict = (32'(occupancy) >= 32'(capacity_in_use)) ||
                      (32'(occupancy) >= MAX_ENTRIES);

  always_comb begin
    state_next     = state;
    occupancy_next = occupancy;
    sel            = '0;
    cmd.op         = CELL_HOLD;
    cmd.key        = req_key;
    cmd.value      = req_value;
    cmd.ref_rank   = hit_rank;
    cmd.occ        = occupancy;
    load_out       = 1'b0;
    load_pend      = 1'b0;
    new_hit        = any_hit;
    new_value      = any_hit ? hit_value : '1;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!req_put) begin
          if (any_hit) begin
            cmd.op = CELL_TOUCH;
            sel    = hit_vec;
          end
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            load_pend  = 1'b1;
            state_next = ST_RESP;
          end
        end else if (capacity_in_use == '0) begin
          state_next = ST_IDLE;
        end else if (any_hit) begin
          cmd.op     = CELL_UPDATE;
          sel        = hit_vec;
          state_next = ST_IDLE;
        end else if (need_evict) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FILL;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == OCC_W'(MAX_ENTRIES - 1)) state_next = ST_EVICT;
      end
      ST_EVICT: begin
        cmd.op       = CELL_EVICT;
        cmd.ref_rank = cand[MAX_ENTRIES-1].rank;
        sel[cand[MAX_ENTRIES-1].idx] = cand[MAX_ENTRIES-1].valid;
        if (cand[MAX_ENTRIES-1].valid) occupancy_next = occupancy - 1'b1;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.op = CELL_FILL;
        if (!valid_vec[free_idx]) begin
          sel[free_idx]  = 1'b1;
          occupancy_next = occupancy + 1'b1;
        end
        state_next = ST_IDLE;
      end
      ST_RESP: begin
        new_hit   = pend_hit;
        new_value = pend_value;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      occupancy       <= '0;
      capacity_in_use <= CAP_W'(16);
      scan_cnt        <= '0;
      out_valid       <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      if (cfg_write) capacity_in_use <= cfg_data;
      if (state == ST_SCAN) scan_cnt <= scan_cnt + 1'b1;
      else scan_cnt <= '0;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_put   <= req_type;
      req_key   <= lookup_key;
      req_value <= store_value;
    end
    if (load_pend) begin
      pend_hit   <= new_hit;
      pend_value <= new_value;
    end
    if (load_out) begin
      hit        <= new_hit;
      read_value <= new_value;
    end
  end

  a_hit_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_vec))
    else $error("more than one entry matches the key");

  a_occ_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(occupancy))
    else $error("occupancy out of step with valid entries");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) <= MAX_ENTRIES)
    else $error("occupancy exceeds table size");

  a_evict_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVICT |-> cand[MAX_ENTRIES-1].valid)
    else $error("eviction without a victim");

endmodule
